// ===== design/lowest_free_id_allocator_macros.svh =====
// ----------------------------------------------------------------------------
// Lowest free ID allocator - assertion macros
// Shared concurrent assertion forms used by the allocator modules.
// ----------------------------------------------------------------------------
`ifndef LOWEST_FREE_ID_ALLOCATOR_MACROS_SVH
`define LOWEST_FREE_ID_ALLOCATOR_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define LFID_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lfid assertion failed");

// Next-cycle implication, checked outside reset.
`define LFID_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lfid assertion failed");

`endif

// ===== design/lfid_pkg.sv =====
// ----------------------------------------------------------------------------
// Lowest free ID allocator - package
// Widths, codes, types and helper functions shared by the allocator files.
// ----------------------------------------------------------------------------
package lfid_pkg;

   localparam int MAX_IDS     = 1024;
   localparam int ID_W        = 10;
   localparam int CNT_W       = 11;
   localparam int ACTION_W    = 2;
   localparam int WORD_W      = 32;
   localparam int BIT_IDX_W   = $clog2(WORD_W);
   localparam int NUM_WORDS   = MAX_IDS / WORD_W;
   localparam int WORD_IDX_W  = $clog2(NUM_WORDS);

   localparam logic [CNT_W-1:0] ID_COUNT_RESET = CNT_W'(MAX_IDS);

   typedef enum logic [ACTION_W-1:0] {
      ACT_ALLOC   = 2'd0,
      ACT_CHECK   = 2'd1,
      ACT_RELEASE = 2'd2
   } action_type;

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

   typedef struct packed {
      logic                  en;
      logic [WORD_IDX_W-1:0] word_idx;
      logic                  nonzero;
   } sum_upd_type;

   function automatic logic [WORD_IDX_W-1:0] lowest_word(input logic [NUM_WORDS-1:0] v);
      logic [WORD_IDX_W-1:0] idx;
      idx = '0;
      for (int i = NUM_WORDS - 1; i >= 0; i--) begin
         if (v[i]) begin
            idx = WORD_IDX_W'(i);
         end
      end
      return idx;
   endfunction

   function automatic logic [BIT_IDX_W-1:0] lowest_bit(input logic [WORD_W-1:0] v);
      logic [BIT_IDX_W-1:0] idx;
      idx = '0;
      for (int i = WORD_W - 1; i >= 0; i--) begin
         if (v[i]) begin
            idx = BIT_IDX_W'(i);
         end
      end
      return idx;
   endfunction

endpackage

// ===== design/lfid_req_if.sv =====
// ----------------------------------------------------------------------------
// Lowest free ID allocator - request channel
// Valid/ready channel carrying one request: action and number.
// ----------------------------------------------------------------------------
interface lfid_req_if;
   import lfid_pkg::*;

   logic                valid;
   logic                ready;
   logic [ACTION_W-1:0] action;
   logic [ID_W-1:0]     number;

   modport source (output valid, output action, output number, input ready);
   modport sink   (input valid, input action, input number, output ready);
endinterface

// ===== design/lfid_rsp_if.sv =====
// ----------------------------------------------------------------------------
// Lowest free ID allocator - response channel
// Valid/ready channel carrying one response per request.
// ----------------------------------------------------------------------------
interface lfid_rsp_if;
   import lfid_pkg::*;

   logic            valid;
   logic            ready;
   logic [ID_W-1:0] granted_id;
   logic            grant_valid;
   logic            is_free;
   logic            out_of_range;

   modport source (output valid, output granted_id, output grant_valid,
                   output is_free, output out_of_range, input ready);
   modport sink   (input valid, input granted_id, input grant_valid,
                   input is_free, input out_of_range, output ready);
endinterface

// ===== design/lowest_free_id_allocator.sv =====
// ----------------------------------------------------------------------------
// Lowest free ID allocator
// Bitmap ID allocator: allocate lowest free ID, check or release a number.
// ----------------------------------------------------------------------------
// Usage:
//   req_ch (sink) carries action and number; rsp_ch (source) returns one
//   response per request: granted_id, grant_valid, is_free, out_of_range.
//   csr_wr_en/csr_wr_data write id_count; write only while no request is in
//   flight. Numbers at or above id_count are flagged out of range.
//   The free bitmap is 32 words of 32 bits in a one-port-read RAM, plus a
//   summary register with one bit per word that points the allocate search
//   at the word holding the lowest free ID.
//   Flow: a request transfers in ST_IDLE, which issues the RAM read; in
//   ST_EXEC the word is modified and written back and the response is
//   registered. No new request is taken until ST_EXEC is done, set by the
//   read-modify-write of one RAM word per request.
//   Reset: all IDs free, id_count = 1024, no clearing pass; words not yet
//   written read as all free through per-word valid flags.
//   Stall: a new request may transfer while a response waits; it then holds
//   in the modify step until the response register frees.
// ----------------------------------------------------------------------------
`include "lowest_free_id_allocator_macros.svh"

module lowest_free_id_allocator (
   input  logic                      clock,
   input  logic                      reset,
   lfid_req_if.sink                  req_ch,
   lfid_rsp_if.source                rsp_ch,
   input  logic                      csr_wr_en,
   input  logic [lfid_pkg::CNT_W-1:0] csr_wr_data
);
   import lfid_pkg::*;

   state_type             state_ff, state_in;
   logic [CNT_W-1:0]      count_ff;
   action_type            act_ff;
   logic [ID_W-1:0]       num_ff;
   logic [WORD_IDX_W-1:0] word_idx_ff, word_idx_in;
   logic                  any_ff;
   logic [NUM_WORDS-1:0]  word_valid_ff;

   logic                  rsp_valid_ff;
   logic [ID_W-1:0]       granted_id_ff;
   logic                  grant_valid_ff;
   logic                  is_free_ff;
   logic                  oor_ff;

   logic                  req_xfer;
   logic                  go;
   logic                  rd_en;

   logic [WORD_IDX_W-1:0] sum_lowest;
   logic                  sum_any;
   sum_upd_type           sum_upd;

   logic [WORD_W-1:0]     rd_data;
   logic [WORD_W-1:0]     word;
   logic [BIT_IDX_W-1:0]  bit_idx;
   logic [WORD_W-1:0]     bit_mask;
   logic [ID_W-1:0]       cand_id;
   logic                  grant;
   logic                  num_oor;
   logic                  wr_en;
   logic [WORD_W-1:0]     wr_data;
   logic [ID_W-1:0]       res_granted;
   logic                  res_grant_valid;
   logic                  res_is_free;
   logic                  res_oor;

   lfid_summary u_summary (
      .clock      (clock),
      .reset      (reset),
      .upd        (sum_upd),
      .lowest_idx (sum_lowest),
      .any_free   (sum_any)
   );

   lfid_ram #(
      .WIDTH (WORD_W),
      .DEPTH (NUM_WORDS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (word_idx_ff),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (word_idx_in),
      .rd_data (rd_data)
   );

   // FSM next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (go) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // FSM outputs
   always_comb begin
      req_ch.ready = 1'b0;
      go           = 1'b0;
      unique case (state_ff)
         ST_IDLE: req_ch.ready = !reset;
         ST_EXEC: go = !rsp_valid_ff || rsp_ch.ready;
         default: begin
            req_ch.ready = 1'b0;
            go           = 1'b0;
         end
      endcase
   end

   assign req_xfer    = req_ch.valid && req_ch.ready;
   assign rd_en       = req_xfer;
   assign word_idx_in = (action_type'(req_ch.action) == ACT_ALLOC) ?
                        sum_lowest : req_ch.number[ID_W-1:BIT_IDX_W];

   // Modify step
   always_comb begin
      word            = word_valid_ff[word_idx_ff] ? rd_data : '1;
      bit_idx         = (act_ff == ACT_ALLOC) ? lowest_bit(word) : num_ff[BIT_IDX_W-1:0];
      bit_mask        = WORD_W'(1) << bit_idx;
      cand_id         = {word_idx_ff, bit_idx};
      grant           = any_ff && ({1'b0, cand_id} < count_ff);
      num_oor         = {1'b0, num_ff} >= count_ff;
      wr_data         = word;
      res_granted     = '0;
      res_grant_valid = 1'b0;
      res_is_free     = 1'b0;
      res_oor         = 1'b0;
      wr_en           = 1'b0;
      unique case (act_ff)
         ACT_ALLOC: begin
            if (grant) begin
               res_granted     = cand_id;
               res_grant_valid = 1'b1;
               wr_data         = word & ~bit_mask;
               wr_en           = go;
            end
         end
         ACT_CHECK: begin
            res_oor     = num_oor;
            res_is_free = !num_oor && word[bit_idx];
         end
         ACT_RELEASE: begin
            res_oor = num_oor;
            if (!num_oor) begin
               wr_data = word | bit_mask;
               wr_en   = go;
            end
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
      sum_upd.en       = wr_en;
      sum_upd.word_idx = word_idx_ff;
      sum_upd.nonzero  = |wr_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= ID_COUNT_RESET;
         word_valid_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) begin
            count_ff <= csr_wr_data;
         end
         if (wr_en) begin
            word_valid_ff[word_idx_ff] <= 1'b1;
         end
         if (go) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         act_ff      <= action_type'(req_ch.action);
         num_ff      <= req_ch.number;
         word_idx_ff <= word_idx_in;
         any_ff      <= sum_any;
      end
      if (go) begin
         granted_id_ff  <= res_granted;
         grant_valid_ff <= res_grant_valid;
         is_free_ff     <= res_is_free;
         oor_ff         <= res_oor;
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.granted_id   = granted_id_ff;
   assign rsp_ch.grant_valid  = grant_valid_ff;
   assign rsp_ch.is_free      = is_free_ff;
   assign rsp_ch.out_of_range = oor_ff;

   `LFID_ASSERT_NEXT(a_xfer_to_exec, clock, reset, req_xfer, state_ff == ST_EXEC)
   `LFID_ASSERT_IMPLY(a_write_in_exec, clock, reset, wr_en, go && state_ff == ST_EXEC)
   `LFID_ASSERT_IMPLY(a_rsp_flags_excl, clock, reset, rsp_valid_ff,
                      $onehot0({grant_valid_ff, is_free_ff, oor_ff}))
   `LFID_ASSERT_IMPLY(a_grant_in_range, clock, reset, rsp_valid_ff && grant_valid_ff,
                      ({1'b0, granted_id_ff} < count_ff))

endmodule

// ===== design/lfid_ram.sv =====
// ----------------------------------------------------------------------------
// Lowest free ID allocator - generic RAM
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module lfid_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/lfid_summary.sv =====
// ----------------------------------------------------------------------------
// Lowest free ID allocator - word summary
// One bit per bitmap word, set while the word holds a free ID, with a
// lowest-set-word encoder for the allocate search.
// ----------------------------------------------------------------------------
`include "lowest_free_id_allocator_macros.svh"

module lfid_summary (
   input  logic                           clock,
   input  logic                           reset,
   input  lfid_pkg::sum_upd_type          upd,
   output logic [lfid_pkg::WORD_IDX_W-1:0] lowest_idx,
   output logic                           any_free
);
   import lfid_pkg::*;

   logic [NUM_WORDS-1:0] summary_ff;
   logic [NUM_WORDS-1:0] summary_in;

   always_comb begin
      summary_in = summary_ff;
      if (upd.en) begin
         summary_in[upd.word_idx] = upd.nonzero;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         summary_ff <= '1;
      end else begin
         summary_ff <= summary_in;
      end
   end

   assign lowest_idx = lowest_word(summary_ff);
   assign any_free   = |summary_ff;

   `LFID_ASSERT_NEXT(a_sum_update, clock, reset, upd.en,
                     summary_ff[$past(upd.word_idx)] == $past(upd.nonzero))
   `LFID_ASSERT_IMPLY(a_sum_lowest_set, clock, reset, any_free, summary_ff[lowest_idx])

endmodule

// ===== tb/sv/lfid_grant_checker.sv =====
// ----------------------------------------------------------------------------
// Lowest free ID allocator - grant checker
// Watches the request, response and CSR ports. It keeps its own copy of the
// free bitmap and id_count, works out the response for each request
// transfer, and compares every response transfer with the oldest owed one.
// ----------------------------------------------------------------------------
module lfid_grant_checker (
   input  logic                       clock,
   input  logic                       reset,
   lfid_req_if                        req_mon,
   lfid_rsp_if                        rsp_mon,
   input  logic                       csr_wr_en,
   input  logic [lfid_pkg::CNT_W-1:0] csr_wr_data,
   output int                         mismatches,
   output int                         owed
);
   import lfid_pkg::*;

   typedef struct packed {
      logic [ID_W-1:0] granted_id;
      logic            grant_valid;
      logic            is_free;
      logic            out_of_range;
   } id_rsp_type;

   logic [MAX_IDS-1:0] free_ids;
   logic [CNT_W-1:0]   id_count;
   id_rsp_type         owed_rsps[$];
   int                 fail_count = 0;
   int                 owed_count = 0;

   assign mismatches = fail_count;
   assign owed       = owed_count;

   task automatic report_mismatch(input string msg);
      if (fail_count < 200) begin
         $display("%0t lfid check: %s", $time, msg);
      end
      fail_count++;
   endtask

   task automatic serve_request(input logic [ACTION_W-1:0] act, input logic [ID_W-1:0] num,
                                output id_rsp_type rsp);
      int limit;
      limit = (id_count > MAX_IDS) ? MAX_IDS : int'(id_count);
      rsp   = '0;
      case (act)
         ACT_ALLOC: begin
            for (int i = 0; i < limit && !rsp.grant_valid; i++) begin
               if (free_ids[i]) begin
                  free_ids[i]     = 1'b0;
                  rsp.granted_id  = ID_W'(i);
                  rsp.grant_valid = 1'b1;
               end
            end
         end
         ACT_CHECK: begin
            if (int'(num) < limit) rsp.is_free = free_ids[num];
            else rsp.out_of_range = 1'b1;
         end
         ACT_RELEASE: begin
            if (int'(num) < limit) free_ids[num] = 1'b1;
            else rsp.out_of_range = 1'b1;
         end
         default: begin
         end
      endcase
   endtask

   always @(posedge clock) begin
      id_rsp_type want;
      id_rsp_type fresh;
      if (reset) begin
         free_ids = '1;
         id_count = ID_COUNT_RESET;
         owed_rsps.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (owed_rsps.size() == 0) begin
               report_mismatch("response transfer with nothing owed");
            end else begin
               want = owed_rsps.pop_front();
               if (rsp_mon.granted_id !== want.granted_id)
                  report_mismatch($sformatf("granted_id got %0d want %0d",
                                            rsp_mon.granted_id, want.granted_id));
               if (rsp_mon.grant_valid !== want.grant_valid)
                  report_mismatch($sformatf("grant_valid got %b want %b",
                                            rsp_mon.grant_valid, want.grant_valid));
               if (rsp_mon.is_free !== want.is_free)
                  report_mismatch($sformatf("is_free got %b want %b",
                                            rsp_mon.is_free, want.is_free));
               if (rsp_mon.out_of_range !== want.out_of_range)
                  report_mismatch($sformatf("out_of_range got %b want %b",
                                            rsp_mon.out_of_range, want.out_of_range));
            end
         end
         if (csr_wr_en) begin
            id_count = csr_wr_data;
         end
         if (req_mon.valid && req_mon.ready) begin
            serve_request(req_mon.action, req_mon.number, fresh);
            owed_rsps.push_back(fresh);
         end
      end
      owed_count = owed_rsps.size();
   end

endmodule

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// Lowest free ID allocator - testbench top
// Drives directed and random allocate/check/release traffic through several
// id_count settings (zero, one, two, mid sizes, full and above full), with
// random gaps on both channels and one long response hold-off. The grant
// checker predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
   import lfid_pkg::*;

   localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
   localparam int RSP_HOLD_CYCLES = 150;
   localparam int WATCHDOG_LIMIT  = 2000;
   localparam int DRAIN_CYCLES    = 8;

   logic             clock;
   logic             reset;
   logic             csr_wr_en;
   logic [CNT_W-1:0] csr_wr_data;
   int               mismatches;
   int               owed;
   int               idle_pct     = 17;
   int               hold_trigger = 0;
   int               hold_at      = 0;
   int               sent_items   = 0;
   int               count_writes = 0;
   int               quiet_cycles = 0;

   lfid_req_if req_ch ();
   lfid_rsp_if rsp_ch ();

   lowest_free_id_allocator u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   lfid_grant_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_ch),
      .rsp_mon     (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .mismatches  (mismatches),
      .owed        (owed)
   );

   initial clock = 1'b0;
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // response side: random ready, plus a long hold-off on request
   initial begin
      int hold_seen;
      hold_seen    = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_trigger != hold_seen) begin
            hold_seen = hold_trigger;
            rsp_ch.ready <= 1'b0;
            repeat (RSP_HOLD_CYCLES - 1) @(negedge clock);
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("tb_top: done, errors");
         $finish;
      end
   end

   // called at a falling edge, returns at the falling edge after the transfer
   task automatic issue_request(input logic [ACTION_W-1:0] act, input logic [ID_W-1:0] num);
      while ($urandom_range(99) < idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid  <= 1'b1;
      req_ch.action <= act;
      req_ch.number <= num;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      sent_items++;
      @(negedge clock);
   endtask

   task automatic set_id_count(input logic [CNT_W-1:0] value);
      req_ch.valid <= 1'b0;
      while (owed != 0) @(negedge clock);
      repeat (4) @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      count_writes++;
   endtask

   task automatic run_random_phase(input logic [CNT_W-1:0] cnt, input int n_items,
                                   input int alloc_pct, input int check_pct);
      int                  eff;
      int                  span;
      int                  pick;
      logic [ACTION_W-1:0] act;
      logic [ID_W-1:0]     num;
      set_id_count(cnt);
      eff = (cnt > MAX_IDS) ? MAX_IDS : int'(cnt);
      repeat (n_items) begin
         pick = $urandom_range(99);
         if (pick < alloc_pct) act = ACT_ALLOC;
         else if (pick < alloc_pct + check_pct) act = ACT_CHECK;
         else if (pick < 97) act = ACT_RELEASE;
         else act = ACT_UNUSED;
         span = (eff < MAX_IDS) ? eff : MAX_IDS - 1;
         if (span > 63 && $urandom_range(1) == 1) span = 63;
         if ($urandom_range(9) == 0) num = ID_W'($urandom_range(MAX_IDS - 1));
         else num = ID_W'($urandom_range(span));
         issue_request(act, num);
      end
   endtask

   initial begin
      reset         = 1'b1;
      csr_wr_en     = 1'b0;
      csr_wr_data   = '0;
      req_ch.valid  = 1'b0;
      req_ch.action = ACT_ALLOC;
      req_ch.number = '0;
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset count, all free
      issue_request(ACT_ALLOC,   10'd0);
      issue_request(ACT_ALLOC,   10'd1023);
      issue_request(ACT_CHECK,   10'd0);
      issue_request(ACT_CHECK,   10'd2);
      issue_request(ACT_CHECK,   10'd1023);
      issue_request(ACT_RELEASE, 10'd1023);   // already free
      issue_request(ACT_RELEASE, 10'd0);
      issue_request(ACT_CHECK,   10'd0);
      issue_request(ACT_ALLOC,   10'd0);
      issue_request(ACT_UNUSED,  10'd1023);
      issue_request(ACT_UNUSED,  10'd0);
      // count shrunk to the used ids: nothing left, out of range
      set_id_count(11'd2);
      issue_request(ACT_ALLOC,   10'd0);
      issue_request(ACT_CHECK,   10'd2);
      issue_request(ACT_RELEASE, 10'd1023);
      issue_request(ACT_RELEASE, 10'd1);
      issue_request(ACT_ALLOC,   10'd0);
      // zero count
      set_id_count(11'd0);
      issue_request(ACT_ALLOC,   10'd0);
      issue_request(ACT_CHECK,   10'd0);
      issue_request(ACT_RELEASE, 10'd0);
      // count above the maximum
      set_id_count(11'd2047);
      issue_request(ACT_ALLOC,   10'd0);
      issue_request(ACT_CHECK,   10'd1023);
      issue_request(ACT_RELEASE, 10'd2);

      run_random_phase(11'd40, 350, 45, 25);
      run_random_phase(11'd0, 40, 40, 30);
      // hold-off starts mid-phase so requests keep coming while it lasts
      hold_at = sent_items + 100;
      fork
         begin
            wait (sent_items >= hold_at);
            hold_trigger++;
         end
      join_none
      run_random_phase(11'd2047, 350, 60, 20);
      run_random_phase(11'd1, 60, 45, 25);
      idle_pct = 0;
      run_random_phase(11'd1024, 350, 70, 15);
      idle_pct = 17;
      run_random_phase(11'd700, 250, 45, 25);

      req_ch.valid <= 1'b0;
      while (owed != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("tb_top: %0d requests over %0d id_count writes (0, 1, 2, 40, 700, 1024, 2047),",
               sent_items, count_writes);
      $display("tb_top: exhaustion, out-of-range, unused action and a %0d-cycle response hold-off",
               RSP_HOLD_CYCLES);
      if (mismatches == 0) begin
         $display("tb_top: done, clean");
      end else begin
         $display("tb_top: done, errors");
      end
      $finish;
   end

endmodule
